[src/selective_repeat_send_window_defines.svh]
// Assertion helpers used by srsw_back.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SRSW_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRSW_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/srsw_pkg.sv]
package srsw_pkg;

    localparam int SEQ_W       = 32;
    localparam int WIN_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    // input kind codes
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NACK = 2'd2;

    // result action codes
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_RESEND = 2'd2;
    localparam logic [1:0] ACT_REFUSE = 2'd3;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_NACK,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SEQ_W-1:0]  seq;
    } item_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SLIDE,
        B_MOD
    } back_state_t;

    // One restoring step of remainder by a window size below 32.
    function automatic logic [WIN_W-1:0] rem_step(logic [WIN_W-1:0] rem, logic b,
                                                  logic [WIN_W-1:0] w);
        logic [WIN_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, w})
        begin
            t = t - {1'b0, w};
        end
        return t[WIN_W-1:0];
    endfunction

endpackage

[src/selective_repeat_send_window.sv]
// Path: a send request, NACK or unknown kind passes the front register and the queue, and its
//   result is registered when it is popped; an ACK first slides the base past each marked slot.
// Throughput: one item per cycle for send and NACK unless out_stall holds; ACKs block while sliding.
// A window size write starts a remainder pass that re-derives the slot counters;
//   items are queued but not executed meanwhile.
// Reset: sequence counters, slots and marks cleared, window size 1, queue and result empty.
module selective_repeat_send_window
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         win_limit_we,
    input  logic [srsw_pkg::WIN_W-1:0]   win_limit,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [srsw_pkg::SEQ_W-1:0]   ack_seq,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   action,
    output logic [srsw_pkg::SEQ_W-1:0]   seq_out,
    output logic [3:0]                   slot_out,
    output logic [srsw_pkg::SEQ_W-1:0]   window_base,
    output logic [srsw_pkg::WIN_W-1:0]   outstanding,
    output logic                         all_acked
);

    logic            push;
    srsw_pkg::item_t push_item;
    logic            q_full;
    logic            q_empty;
    logic            pop;
    srsw_pkg::item_t q_item;

    srsw_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .ack_seq   (ack_seq),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    srsw_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    srsw_back
    #(
        .MAX_WINDOW (MAX_WINDOW)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .win_limit_we (win_limit_we),
        .win_limit    (win_limit),
        .q_empty      (q_empty),
        .q_item       (q_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .seq_out      (seq_out),
        .slot_out     (slot_out),
        .window_base  (window_base),
        .outstanding  (outstanding),
        .all_acked    (all_acked)
    );

endmodule

[src/srsw_front.sv]
module srsw_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [srsw_pkg::SEQ_W-1:0]   ack_seq,
    output logic                         push,
    output srsw_pkg::item_t              push_item,
    input  logic                         q_full
);

    logic            held_valid_reg;
    logic            held_valid_next;
    srsw_pkg::item_t held_item_reg;
    srsw_pkg::op_t   op_dec;
    logic            load;

    always_comb
    begin
        case (kind)
            srsw_pkg::KIND_SEND: op_dec = srsw_pkg::OP_SEND;
            srsw_pkg::KIND_ACK:  op_dec = srsw_pkg::OP_ACK;
            srsw_pkg::KIND_NACK: op_dec = srsw_pkg::OP_NACK;
            default:             op_dec = srsw_pkg::OP_NOP;
        endcase
    end

    assign in_stall  = held_valid_reg && q_full;
    assign load      = in_valid && !in_stall;
    assign push      = held_valid_reg && !q_full;
    assign push_item = held_item_reg;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        if (load)
        begin
            held_valid_next = 1'b1;
        end
        else if (push)
        begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_item_reg.op  <= op_dec;
            held_item_reg.seq <= ack_seq;
        end
    end

endmodule

[src/srsw_fifo.sv]
module srsw_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  srsw_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output srsw_pkg::item_t pop_item,
    output logic            empty
);

    localparam int DEPTH = srsw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srsw_pkg::item_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/srsw_back.sv]
`include "selective_repeat_send_window_defines.svh"

module srsw_back
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         win_limit_we,
    input  logic [srsw_pkg::WIN_W-1:0]   win_limit,
    input  logic                         q_empty,
    input  srsw_pkg::item_t              q_item,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   action,
    output logic [srsw_pkg::SEQ_W-1:0]   seq_out,
    output logic [3:0]                   slot_out,
    output logic [srsw_pkg::SEQ_W-1:0]   window_base,
    output logic [srsw_pkg::WIN_W-1:0]   outstanding,
    output logic                         all_acked
);

    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WCAP  = (MAX_WINDOW > 31) ? 31 : MAX_WINDOW;
    localparam int SEQ_W = srsw_pkg::SEQ_W;
    localparam int WIN_W = srsw_pkg::WIN_W;

    srsw_pkg::back_state_t state_reg;
    srsw_pkg::back_state_t state_next;

    logic [SEQ_W-1:0]      base_seq_reg,  base_seq_next;
    logic [SEQ_W-1:0]      next_seq_reg,  next_seq_next;
    logic [SW-1:0]         base_slot_reg, base_slot_next;
    logic [SW-1:0]         next_slot_reg, next_slot_next;
    logic [WIN_W-1:0]      outst_reg,     outst_next;
    logic [WIN_W-1:0]      win_reg,       win_next;
    logic [MAX_WINDOW-1:0] marks_reg,     marks_next;
    logic [4:0]            mod_idx_reg,   mod_idx_next;
    logic [WIN_W-1:0]      rem_b_reg,     rem_b_next;
    logic [WIN_W-1:0]      rem_n_reg,     rem_n_next;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            act_reg,       act_next;
    logic [SEQ_W-1:0]      oseq_reg,      oseq_next;
    logic [SW-1:0]         oslot_reg,     oslot_next;
    logic [SEQ_W-1:0]      obase_reg,     obase_next;
    logic [WIN_W-1:0]      oout_reg,      oout_next;

    logic                  out_free;
    logic                  out_load;
    logic [SEQ_W-1:0]      off;
    logic                  in_window;
    logic                  ack_hit;
    logic [6:0]            idx_sum;
    logic [6:0]            idx_wrap;
    logic [SW-1:0]         idx;
    logic                  can_send;
    logic                  advance;
    logic [6:0]            base_inc;
    logic [6:0]            next_inc;
    logic [SW-1:0]         base_step;
    logic [SW-1:0]         next_step;
    logic [WIN_W-1:0]      eff_win;
    logic [WIN_W-1:0]      rem_b_new;
    logic [WIN_W-1:0]      rem_n_new;
    logic [6:0]            rem_b_ext;
    logic [6:0]            rem_n_ext;
    logic [6:0]            oslot_ext;

    // ---- shared datapath ----
    assign out_free  = !out_valid_reg || !out_stall;
    assign off       = q_item.seq - base_seq_reg;
    assign in_window = (q_item.seq >= base_seq_reg) && (off < SEQ_W'(win_reg));
    assign ack_hit   = in_window && (off < SEQ_W'(outst_reg));
    // off < window here, so one conditional subtract wraps the slot
    assign idx_sum   = 7'(base_slot_reg) + 7'(off[WIN_W-1:0]);
    assign idx_wrap  = (idx_sum >= 7'(win_reg)) ? idx_sum - 7'(win_reg) : idx_sum;
    assign idx       = idx_wrap[SW-1:0];
    assign can_send  = (outst_reg < win_reg) && !(&next_seq_reg);
    assign advance   = (outst_reg != '0) && marks_reg[base_slot_reg];

    assign base_inc  = 7'(base_slot_reg) + 7'd1;
    assign next_inc  = 7'(next_slot_reg) + 7'd1;
    assign base_step = (base_inc >= 7'(win_reg)) ? '0 : base_inc[SW-1:0];
    assign next_step = (next_inc >= 7'(win_reg)) ? '0 : next_inc[SW-1:0];

    always_comb
    begin
        if (win_limit == '0)
        begin
            eff_win = WIN_W'(1);
        end
        else if (32'(win_limit) > WCAP)
        begin
            eff_win = WIN_W'(WCAP);
        end
        else
        begin
            eff_win = win_limit;
        end
    end

    assign rem_b_new = srsw_pkg::rem_step(rem_b_reg, base_seq_reg[mod_idx_reg], win_reg);
    assign rem_n_new = srsw_pkg::rem_step(rem_n_reg, next_seq_reg[mod_idx_reg], win_reg);
    assign rem_b_ext = 7'(rem_b_new);
    assign rem_n_ext = 7'(rem_n_new);

    assign pop = (state_reg == srsw_pkg::B_IDLE) && !q_empty &&
                 ((q_item.op == srsw_pkg::OP_ACK) || out_free);

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srsw_pkg::B_IDLE:
            begin
                if (pop && (q_item.op == srsw_pkg::OP_ACK))
                begin
                    state_next = srsw_pkg::B_SLIDE;
                end
            end
            srsw_pkg::B_SLIDE:
            begin
                if (!advance && out_free)
                begin
                    state_next = srsw_pkg::B_IDLE;
                end
            end
            srsw_pkg::B_MOD:
            begin
                if (mod_idx_reg == '0)
                begin
                    state_next = srsw_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = srsw_pkg::B_IDLE;
            end
        endcase
        if (win_limit_we)
        begin
            state_next = srsw_pkg::B_MOD;
        end
    end

    // ---- datapath and result ----
    always_comb
    begin
        base_seq_next  = base_seq_reg;
        next_seq_next  = next_seq_reg;
        base_slot_next = base_slot_reg;
        next_slot_next = next_slot_reg;
        outst_next     = outst_reg;
        win_next       = win_reg;
        marks_next     = marks_reg;
        mod_idx_next   = mod_idx_reg;
        rem_b_next     = rem_b_reg;
        rem_n_next     = rem_n_reg;
        act_next       = act_reg;
        oseq_next      = oseq_reg;
        oslot_next     = oslot_reg;
        obase_next     = obase_reg;
        oout_next      = oout_reg;
        out_load       = 1'b0;

        case (state_reg)
            srsw_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    act_next   = srsw_pkg::ACT_NONE;
                    oseq_next  = '0;
                    oslot_next = '0;
                    case (q_item.op)
                        srsw_pkg::OP_SEND:
                        begin
                            out_load = 1'b1;
                            if (can_send)
                            begin
                                act_next       = srsw_pkg::ACT_SEND;
                                oseq_next      = next_seq_reg;
                                oslot_next     = next_slot_reg;
                                next_seq_next  = next_seq_reg + 1'b1;
                                next_slot_next = next_step;
                                outst_next     = outst_reg + 1'b1;
                            end
                            else
                            begin
                                act_next = srsw_pkg::ACT_REFUSE;
                            end
                        end
                        srsw_pkg::OP_ACK:
                        begin
                            if (ack_hit)
                            begin
                                marks_next[idx] = 1'b1;
                            end
                        end
                        srsw_pkg::OP_NACK:
                        begin
                            out_load = 1'b1;
                            if (in_window)
                            begin
                                act_next   = srsw_pkg::ACT_RESEND;
                                oseq_next  = q_item.seq;
                                oslot_next = idx;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                    obase_next = base_seq_reg;
                    oout_next  = outst_next;
                end
            end
            srsw_pkg::B_SLIDE:
            begin
                if (advance)
                begin
                    marks_next[base_slot_reg] = 1'b0;
                    base_seq_next  = base_seq_reg + 1'b1;
                    base_slot_next = base_step;
                    outst_next     = outst_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    act_next   = srsw_pkg::ACT_NONE;
                    oseq_next  = '0;
                    oslot_next = '0;
                    obase_next = base_seq_reg;
                    oout_next  = outst_reg;
                end
            end
            srsw_pkg::B_MOD:
            begin
                // base and next seq modulo the window, one bit per cycle, MSB first
                rem_b_next   = rem_b_new;
                rem_n_next   = rem_n_new;
                mod_idx_next = mod_idx_reg - 1'b1;
                if (mod_idx_reg == '0)
                begin
                    base_slot_next = rem_b_ext[SW-1:0];
                    next_slot_next = rem_n_ext[SW-1:0];
                end
            end
            default:
            begin
            end
        endcase

        if (win_limit_we)
        begin
            win_next     = eff_win;
            marks_next   = '0;
            mod_idx_next = 5'd31;
            rem_b_next   = '0;
            rem_n_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srsw_pkg::B_IDLE;
            base_seq_reg  <= '0;
            next_seq_reg  <= '0;
            base_slot_reg <= '0;
            next_slot_reg <= '0;
            outst_reg     <= '0;
            win_reg       <= WIN_W'(1);
            marks_reg     <= '0;
            mod_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_seq_reg  <= base_seq_next;
            next_seq_reg  <= next_seq_next;
            base_slot_reg <= base_slot_next;
            next_slot_reg <= next_slot_next;
            outst_reg     <= outst_next;
            win_reg       <= win_next;
            marks_reg     <= marks_next;
            mod_idx_reg   <= mod_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result fields change only when a new result is loaded
    always_ff @(posedge clk)
    begin
        rem_b_reg <= rem_b_next;
        rem_n_reg <= rem_n_next;
        if (out_load)
        begin
            act_reg   <= act_next;
            oseq_reg  <= oseq_next;
            oslot_reg <= oslot_next;
            obase_reg <= obase_next;
            oout_reg  <= oout_next;
        end
    end

    assign oslot_ext   = 7'(oslot_reg);
    assign out_valid   = out_valid_reg;
    assign action      = act_reg;
    assign seq_out     = oseq_reg;
    assign slot_out    = oslot_ext[3:0];
    assign window_base = obase_reg;
    assign outstanding = oout_reg;
    assign all_acked   = (oout_reg == '0);

    `SRSW_CHECK(a_pop_only_idle, pop, state_reg == srsw_pkg::B_IDLE,
        "queue popped outside idle")
    `SRSW_CHECK(a_no_overwrite, out_load, !(out_valid_reg && out_stall),
        "result register overwritten while stalled")
    `SRSW_CHECK(a_slots_in_window, state_reg != srsw_pkg::B_MOD,
        (7'(base_slot_reg) < 7'(win_reg)) && (7'(next_slot_reg) < 7'(win_reg)),
        "slot counter outside window")
    `SRSW_CHECK_NEXT(a_slide_retires, (state_reg == srsw_pkg::B_SLIDE) && advance,
        outst_reg == $past(outst_reg) - 5'd1, "slide step did not retire a packet")

endmodule
